@@ rtl/rrts_pkg.sv @@
// Package for the round-robin task switcher.
// Holds the sizing constants, command/status/reason codes, FSM states and the result record.
// No dependencies; imported by round_robin_task_switcher, rrts_result_check and the bench top.
`default_nettype none

package rrts_pkg;

    // Table sizing
    localparam int NUM_TASKS   = 4;
    localparam int STACK_BYTES = 256;
    localparam int GUARD_LEN   = 16;
    localparam int FRAME_BYTES = 36;
    localparam int SLOT_W      = $clog2(NUM_TASKS);

    // Field widths of the beats
    localparam int ADDR_W      = 16;
    localparam int SLOT_OUT_W  = 4;
    localparam int STATUS_W    = 2;
    localparam int REASON_W    = 2;

    // Offset from stack base to the initial stack pointer (wraps at 16 bits)
    localparam logic [ADDR_W-1:0] INIT_OFFSET = ADDR_W'(STACK_BYTES - FRAME_BYTES);

    // Command codes
    localparam logic CMD_CREATE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_HALTED = 2'd2;

    // Crash reasons
    localparam logic [REASON_W-1:0] REASON_NONE   = 2'd0;
    localparam logic [REASON_W-1:0] REASON_BOUND  = 2'd1;
    localparam logic [REASON_W-1:0] REASON_CANARY = 2'd2;
    localparam logic [REASON_W-1:0] REASON_EMPTY  = 2'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CHECK,
        ST_SCAN,
        ST_SP_DATA,
        ST_DONE
    } t_state;

    // One result item
    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [ADDR_W-1:0]     next_sp;
        logic [REASON_W-1:0]   crash_reason;
        logic [SLOT_OUT_W-1:0] crash_slot;
        logic [ADDR_W-1:0]     crash_sp;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/rrts_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the saved stack pointer and stack base tables; no dependencies.
`default_nettype none

module rrts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/round_robin_task_switcher.sv @@
// Round-robin task switcher top level: command sequencer, active bits and output register.
// Depends on rrts_pkg and two rrts_ram instances (saved stack pointers, stack bases).
//
// Usage:
//   Slave channel takes one command beat: s_axis_tuser = cmd (0 create, 1 tick),
//   s_axis_tdata = task_base, current_sp, guard_ok. Master channel returns exactly
//   one result beat per command: m_axis_tuser = status, m_axis_tdata = slot,
//   next_sp, crash_reason, crash_slot, crash_sp.
//   A create passes through the execute and done states to the result register. A
//   tick reads the stack base from RAM, then does the guard and bound check and the
//   pointer write-back, then probes slots in the round-robin scan, then reads the
//   saved pointer and loads the output register. The slot scan sets the tick length.
//   One command is in flight at a time; s_axis_tready is high only while the
//   sequencer is idle. A finished result waits in the output register while the
//   next command is already accepted; if the receiver stalls, the sequencer holds
//   its next result until the output register frees.
//   Reset (synchronous, active low) clears the active bits, the running slot and
//   the halted flag; the tables need no clearing. After a fatal crash every
//   command is answered with status halted until reset.
`default_nettype none

module round_robin_task_switcher
    import rrts_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Command beats
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,  // [15:0] task_base, [31:16] current_sp, [32] guard_ok
    input  wire  [0:0]  s_axis_tuser,  // [0] cmd
    // Result beats
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata,  // [3:0] slot, [19:4] next_sp, [21:20] crash_reason,
                                       // [25:22] crash_slot, [41:26] crash_sp
    output logic [1:0]  m_axis_tuser   // [1:0] status
);

    // Control state
    t_state                r_state, n_state;
    logic [NUM_TASKS-1:0]  r_active, n_active;
    logic [SLOT_W-1:0]     r_cur, n_cur;
    logic                  r_halted, n_halted;
    logic [SLOT_W-1:0]     r_probe, n_probe;
    logic [SLOT_W-1:0]     r_cnt, n_cnt;
    logic                  r_out_valid, n_out_valid;

    // Payload
    logic                  r_cmd;
    logic [ADDR_W-1:0]     r_base_in;
    logic [ADDR_W-1:0]     r_sp;
    logic                  r_guard;
    logic                  r_kill, n_kill;
    t_result               r_res, n_res;
    t_result               r_out;

    // RAM ports
    logic                  w_base_we;
    logic [ADDR_W-1:0]     w_base_rdata;
    logic                  w_sp_we;
    logic [SLOT_W-1:0]     w_sp_waddr;
    logic [ADDR_W-1:0]     w_sp_wdata;
    logic [ADDR_W-1:0]     w_sp_rdata;

    // Decode helpers
    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_full;
    logic [SLOT_W-1:0]     w_free_idx;
    logic                  w_create_ok;
    logic                  w_bound_hit;
    logic                  w_probe_hit;
    logic                  w_scan_last;
    logic [SLOT_W-1:0]     w_cur_inc;
    logic [SLOT_W-1:0]     w_probe_inc;

    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_full      = &r_active;
    assign w_create_ok = (r_state == ST_EXEC) && !r_halted && (r_cmd == CMD_CREATE) && !w_full;
    assign w_bound_hit = {1'b0, r_sp} < ({1'b0, w_base_rdata} + (ADDR_W+1)'(GUARD_LEN));
    assign w_probe_hit = r_active[r_probe];
    assign w_scan_last = (r_cnt == SLOT_W'(NUM_TASKS - 1));
    assign w_cur_inc   = (r_cur == SLOT_W'(NUM_TASKS - 1)) ? '0 : r_cur + 1'b1;
    assign w_probe_inc = (r_probe == SLOT_W'(NUM_TASKS - 1)) ? '0 : r_probe + 1'b1;

    // Lowest free slot
    always_comb begin
        w_free_idx = '0;
        for (int i = NUM_TASKS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                w_free_idx = SLOT_W'(i);
            end
        end
    end

    // Table RAM writes: create fills both, tick saves the running pointer
    assign w_base_we = w_create_ok;
    always_comb begin
        w_sp_we    = 1'b0;
        w_sp_waddr = r_cur;
        w_sp_wdata = r_sp;
        if (w_create_ok) begin
            w_sp_we    = 1'b1;
            w_sp_waddr = w_free_idx;
            w_sp_wdata = r_base_in + INIT_OFFSET;
        end else if (r_state == ST_CHECK) begin
            w_sp_we    = 1'b1;
        end
    end

    rrts_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (NUM_TASKS)
    ) u_base_ram (
        .i_clk   (i_clk),
        .i_we    (w_base_we),
        .i_waddr (w_free_idx),
        .i_wdata (r_base_in),
        .i_raddr (r_cur),
        .o_rdata (w_base_rdata)
    );

    rrts_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (NUM_TASKS)
    ) u_sp_ram (
        .i_clk   (i_clk),
        .i_we    (w_sp_we),
        .i_waddr (w_sp_waddr),
        .i_wdata (w_sp_wdata),
        .i_raddr (r_probe),
        .o_rdata (w_sp_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!r_halted && r_cmd == CMD_TICK) begin
                    n_state = ST_CHECK;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_CHECK: begin
                n_state = r_guard ? ST_SCAN : ST_DONE;
            end
            ST_SCAN: begin
                if (w_probe_hit) begin
                    n_state = ST_SP_DATA;
                end else if (w_scan_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_SP_DATA: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // FSM outputs and datapath updates
    always_comb begin
        n_active    = r_active;
        n_cur       = r_cur;
        n_halted    = r_halted;
        n_probe     = r_probe;
        n_cnt       = r_cnt;
        n_kill      = r_kill;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        s_axis_tready = (r_state == ST_IDLE);

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: ;
            ST_EXEC: begin
                n_res = '0;
                if (r_halted) begin
                    n_res.status = STATUS_HALTED;
                end else if (r_cmd == CMD_CREATE) begin
                    if (w_full) begin
                        n_res.status = STATUS_FULL;
                    end else begin
                        n_active[w_free_idx] = 1'b1;
                        n_res.status  = STATUS_OK;
                        n_res.slot    = SLOT_OUT_W'(w_free_idx);
                        n_res.next_sp = r_base_in + INIT_OFFSET;
                    end
                end
            end
            ST_CHECK: begin
                n_res.crash_slot = SLOT_OUT_W'(r_cur);
                n_res.crash_sp   = r_sp;
                if (!r_guard) begin
                    // Canary damage halts before the bound check
                    n_halted           = 1'b1;
                    n_res.status       = STATUS_HALTED;
                    n_res.crash_reason = REASON_CANARY;
                end else begin
                    n_kill  = w_bound_hit;
                    n_probe = w_cur_inc;
                    n_cnt   = '0;
                    if (w_bound_hit) begin
                        n_active[r_cur] = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                if (!w_probe_hit) begin
                    n_probe = w_probe_inc;
                    n_cnt   = r_cnt + 1'b1;
                    if (w_scan_last) begin
                        // No active slot left
                        n_halted           = 1'b1;
                        n_res.status       = STATUS_HALTED;
                        n_res.crash_reason = REASON_EMPTY;
                    end
                end
            end
            ST_SP_DATA: begin
                n_cur         = r_probe;
                n_res.status  = STATUS_OK;
                n_res.slot    = SLOT_OUT_W'(r_probe);
                n_res.next_sp = w_sp_rdata;
                if (r_kill) begin
                    n_res.crash_reason = REASON_BOUND;
                end else begin
                    n_res.crash_reason = REASON_NONE;
                    n_res.crash_slot   = '0;
                    n_res.crash_sp     = '0;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= '0;
            r_cur       <= '0;
            r_halted    <= 1'b0;
            r_probe     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_cur       <= n_cur;
            r_halted    <= n_halted;
            r_probe     <= n_probe;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_base_in <= s_axis_tdata[15:0];
            r_sp      <= s_axis_tdata[31:16];
            r_guard   <= s_axis_tdata[32];
            r_cmd     <= s_axis_tuser[0];
        end
        r_kill <= n_kill;
        r_res  <= n_res;
        if (r_state == ST_DONE && w_out_free) begin
            r_out <= r_res;
        end
    end

    // Result beat
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {6'd0, r_out.crash_sp, r_out.crash_slot, r_out.crash_reason,
                            r_out.next_sp, r_out.slot};

`ifndef ASSERT_OFF
    // A fatal crash is sticky until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halted flag cleared without reset");

    // A result is only loaded from the final sequencer state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result loaded outside the done state");

    // A switched-to task is active
    a_next_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SP_DATA) |=> r_active[r_cur])
        else $error("scheduled slot is not active");

    // Fatal reasons only come with the halted status
    a_fatal_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_out.crash_reason == REASON_CANARY ||
                           r_out.crash_reason == REASON_EMPTY))
        |-> (r_out.status == STATUS_HALTED))
        else $error("fatal crash reported without halted status");

    // The scan never runs past one full turn
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && w_scan_last) |=> (r_state != ST_SCAN))
        else $error("slot scan exceeded the table size");
`endif

endmodule

`default_nettype wire

@@ bench/rrts_result_check.sv @@
// Result checker for the round-robin task switcher bench: predicts every result beat
// from the accepted command beats and compares it with what the block returns.
// Depends on rrts_pkg; instantiated by round_robin_task_switcher_tb.
`timescale 1ns / 1ps

module rrts_result_check
    import rrts_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // Command channel, watched only
    input  wire                  i_cmd_tvalid,
    input  wire                  i_cmd_tready,
    input  wire  [39:0]          i_cmd_tdata,   // [15:0] task_base, [31:16] current_sp,
                                                // [32] guard_ok
    input  wire  [0:0]           i_cmd_tuser,   // [0] cmd
    // Result channel, watched only
    input  wire                  i_res_tvalid,
    input  wire                  i_res_tready,
    input  wire  [47:0]          i_res_tdata,   // [3:0] slot, [19:4] next_sp,
                                                // [21:20] crash_reason, [25:22] crash_slot,
                                                // [41:26] crash_sp
    input  wire  [1:0]           i_res_tuser,   // [1:0] status
    // Verdict and predicted state, used by the stimulus to stay in contract
    output int                   o_fail_count,
    output int                   o_pending,
    output logic [NUM_TASKS-1:0] o_live,
    output logic [SLOT_W-1:0]    o_run_slot,
    output logic [ADDR_W-1:0]    o_run_base,
    output logic                 o_stopped
);

    localparam int BOUND_W = ADDR_W + 1;

    // Predicted task table
    logic [ADDR_W-1:0]    saved_sp [NUM_TASKS];
    logic [ADDR_W-1:0]    task_base [NUM_TASKS];
    logic [NUM_TASKS-1:0] live     = '0;
    logic [SLOT_W-1:0]    run_slot = '0;
    logic                 stopped  = 1'b0;

    t_result due_results[$];
    int      fails   = 0;
    int      waiting = 0;

    assign o_fail_count = fails;
    assign o_pending    = waiting;
    assign o_live       = live;
    assign o_run_slot   = run_slot;
    assign o_run_base   = task_base[run_slot];
    assign o_stopped    = stopped;

    // Apply one command to the predicted table and build its result
    task automatic schedule_cmd(input logic cmd, input logic [ADDR_W-1:0] base_in,
                                input logic [ADDR_W-1:0] sp_in, input logic guard,
                                output t_result res);
        logic              found;
        logic              killed;
        logic [SLOT_W-1:0] cand;
        logic [SLOT_W-1:0] nxt;
        int                i;
        res = '0;
        found = 1'b0;
        if (stopped) begin
            res.status = STATUS_HALTED;
        end else if (cmd == CMD_CREATE) begin
            // lowest free slot wins
            for (i = 0; i < NUM_TASKS; i++) begin
                if (!found && !live[i]) begin
                    found         = 1'b1;
                    task_base[i]  = base_in;
                    saved_sp[i]   = base_in + ADDR_W'(STACK_BYTES - FRAME_BYTES);
                    live[i]       = 1'b1;
                    res.status    = STATUS_OK;
                    res.slot      = SLOT_OUT_W'(i);
                    res.next_sp   = saved_sp[i];
                end
            end
            if (!found)
                res.status = STATUS_FULL;
        end else begin
            saved_sp[run_slot] = sp_in;
            if (!guard) begin
                // damaged guard halts before the bound is looked at
                stopped          = 1'b1;
                res.status       = STATUS_HALTED;
                res.crash_reason = REASON_CANARY;
                res.crash_slot   = SLOT_OUT_W'(run_slot);
                res.crash_sp     = sp_in;
            end else begin
                // bound sum is taken without wrap
                killed = {1'b0, sp_in} < ({1'b0, task_base[run_slot]} + BOUND_W'(GUARD_LEN));
                if (killed)
                    live[run_slot] = 1'b0;
                // round-robin scan, running slot probed last
                nxt = run_slot;
                for (i = 1; i <= NUM_TASKS; i++) begin
                    cand = SLOT_W'((int'(run_slot) + i) % NUM_TASKS);
                    if (!found && live[cand]) begin
                        found = 1'b1;
                        nxt   = cand;
                    end
                end
                if (!found) begin
                    stopped          = 1'b1;
                    res.status       = STATUS_HALTED;
                    res.crash_reason = REASON_EMPTY;
                    res.crash_slot   = SLOT_OUT_W'(run_slot);
                    res.crash_sp     = sp_in;
                end else begin
                    res.status  = STATUS_OK;
                    res.slot    = SLOT_OUT_W'(nxt);
                    res.next_sp = saved_sp[nxt];
                    if (killed) begin
                        res.crash_reason = REASON_BOUND;
                        res.crash_slot   = SLOT_OUT_W'(run_slot);
                        res.crash_sp     = sp_in;
                    end
                    run_slot = nxt;
                end
            end
        end
    endtask

    // Compare result beats first, then predict from the command beat of the same edge
    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            live     = '0;
            run_slot = '0;
            stopped  = 1'b0;
            due_results.delete();
        end else begin
            if (i_res_tvalid && i_res_tready) begin
                got.status       = i_res_tuser;
                got.slot         = i_res_tdata[3:0];
                got.next_sp      = i_res_tdata[19:4];
                got.crash_reason = i_res_tdata[21:20];
                got.crash_slot   = i_res_tdata[25:22];
                got.crash_sp     = i_res_tdata[41:26];
                if (due_results.size() == 0) begin
                    fails++;
                    $display("%0t: result beat with nothing expected: status=%0d slot=%0d",
                             $time, got.status, got.slot,
                             " next_sp=%h reason=%0d crash_slot=%0d crash_sp=%h",
                             got.next_sp, got.crash_reason, got.crash_slot, got.crash_sp);
                end else begin
                    want = due_results.pop_front();
                    if (got.status !== want.status || got.slot !== want.slot ||
                        got.next_sp !== want.next_sp ||
                        got.crash_reason !== want.crash_reason ||
                        got.crash_slot !== want.crash_slot ||
                        got.crash_sp !== want.crash_sp) begin
                        fails++;
                        $display("%0t: result mismatch: expected status=%0d slot=%0d",
                                 $time, want.status, want.slot,
                                 " next_sp=%h reason=%0d crash_slot=%0d crash_sp=%h;",
                                 want.next_sp, want.crash_reason, want.crash_slot,
                                 want.crash_sp,
                                 " got status=%0d slot=%0d next_sp=%h reason=%0d",
                                 got.status, got.slot, got.next_sp, got.crash_reason,
                                 " crash_slot=%0d crash_sp=%h",
                                 got.crash_slot, got.crash_sp);
                    end
                end
            end
            if (i_cmd_tvalid && i_cmd_tready) begin
                schedule_cmd(i_cmd_tuser[0], i_cmd_tdata[15:0], i_cmd_tdata[31:16],
                             i_cmd_tdata[32], want);
                due_results.push_back(want);
            end
        end
        waiting = due_results.size();
    end

endmodule

@@ bench/round_robin_task_switcher_tb.sv @@
// Top of the round-robin task switcher bench: clock, reset, command stimulus,
// result-side backpressure, watchdog and verdict. Depends on rrts_pkg,
// round_robin_task_switcher and rrts_result_check.
`timescale 1ns / 1ps

module round_robin_task_switcher_tb;
    import rrts_pkg::*;

    localparam int RANDOM_BEATS   = 570;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int BOUND_W        = ADDR_W + 1;
    localparam logic [BOUND_W-1:0] ADDR_MAX = BOUND_W'(16'hFFFF);

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;  // [15:0] task_base, [31:16] current_sp, [32] guard_ok
    logic [0:0]  s_axis_tuser  = '0;  // [0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // [3:0] slot, [19:4] next_sp, [21:20] crash_reason,
                                      // [25:22] crash_slot, [41:26] crash_sp
    logic [1:0]  m_axis_tuser;        // [1:0] status

    int                   fail_count;
    int                   pending;
    logic [NUM_TASKS-1:0] live_map;
    logic [SLOT_W-1:0]    run_slot;
    logic [ADDR_W-1:0]    run_base;
    logic                 stopped;

    int   send_idle_pct = 30;
    int   recv_idle_pct = 50;
    logic hold_req      = 1'b0;
    logic hold_done     = 1'b0;
    int   hold_left     = 0;
    int   quiet_cycles  = 0;

    round_robin_task_switcher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    rrts_result_check result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_tvalid (s_axis_tvalid),
        .i_cmd_tready (s_axis_tready),
        .i_cmd_tdata  (s_axis_tdata),
        .i_cmd_tuser  (s_axis_tuser),
        .i_res_tvalid (m_axis_tvalid),
        .i_res_tready (m_axis_tready),
        .i_res_tdata  (m_axis_tdata),
        .i_res_tuser  (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_live       (live_map),
        .o_run_slot   (run_slot),
        .o_run_base   (run_base),
        .o_stopped    (stopped)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Result side: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left     <= HOLD_CYCLES;
            hold_done     <= 1'b1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: too long without any beat on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one command beat; called and returning at a falling edge
    task automatic send_beat(input logic cmd, input logic [ADDR_W-1:0] base,
                             input logic [ADDR_W-1:0] sp, input logic guard);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, guard, sp, base};
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop offering until every expected result beat has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
    endtask

    // Random create or tick that never ticks an unwritten slot and never halts
    task automatic send_random();
        logic [BOUND_W-1:0] bound;
        logic [ADDR_W-1:0]  base;
        logic [ADDR_W-1:0]  sp;
        logic               do_create;
        int                 n;
        int                 others;
        n      = $countones(live_map);
        others = $countones(live_map & ~(NUM_TASKS'(1) << run_slot));
        bound  = {1'b0, run_base} + BOUND_W'(GUARD_LEN);
        base   = ADDR_W'($urandom_range(16'hFFFF));
        sp     = ADDR_W'($urandom_range(16'hFFFF));
        if (n == 0)
            do_create = 1'b1;
        else if (n == NUM_TASKS)
            do_create = ($urandom_range(99) < 8);
        else
            do_create = ($urandom_range(99) < 35);
        if (!do_create && others != 0 && $urandom_range(99) < 15) begin
            // bound kill; a bound past the address range kills any pointer
            if (bound <= ADDR_MAX)
                sp = ($urandom_range(3) == 0) ? ADDR_W'(bound - 1) :
                                                ADDR_W'($urandom_range(bound - 1, 0));
        end else if (!do_create) begin
            if (bound > ADDR_MAX) begin
                if (others == 0)
                    do_create = 1'b1;
            end else begin
                sp = ($urandom_range(3) == 0) ? ADDR_W'(bound) :
                                                ADDR_W'($urandom_range(16'hFFFF, bound));
            end
        end
        if (do_create) begin
            // bases around the wrap point of the initial pointer and the bound
            case ($urandom_range(15))
                0:       base = 16'h0000;
                1:       base = 16'hFFFF;
                2:       base = 16'hFFEF;
                3:       base = 16'hFFF0;
                4:       base = 16'hFF23;
                5:       base = 16'hFF24;
                default: ;
            endcase
            send_beat(CMD_CREATE, base, sp, 1'($urandom_range(1)));
        end else begin
            send_beat(CMD_TICK, base, sp, 1'b1);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: table fill, wrap of the initial pointer, bound edges, slot reuse
        send_beat(CMD_CREATE, 16'h0000, 16'hFFFF, 1'b0);
        send_beat(CMD_TICK,   16'hFFFF, 16'h4321, 1'b1);  // lone task picked again
        send_beat(CMD_CREATE, 16'hFFFF, 16'h0000, 1'b1);  // initial pointer wraps
        send_beat(CMD_CREATE, 16'h1234, 16'hAAAA, 1'b0);
        send_beat(CMD_CREATE, 16'hFFEF, 16'h5555, 1'b1);
        send_beat(CMD_CREATE, 16'hBEEF, 16'h1111, 1'b1);  // table full
        send_beat(CMD_TICK,   16'h0000, 16'h0010, 1'b1);  // pointer exactly at bound
        send_beat(CMD_TICK,   16'h0000, 16'hFFFF, 1'b1);  // bound past 16 bits kills
        send_beat(CMD_CREATE, 16'h8000, 16'h0000, 1'b1);  // freed slot reused
        send_beat(CMD_TICK,   16'h5A5A, 16'h1243, 1'b1);  // one below bound
        send_beat(CMD_TICK,   16'hA5A5, 16'hFFFF, 1'b1);  // bound equals top address
        send_beat(CMD_TICK,   16'h0000, 16'h000F, 1'b1);
        send_beat(CMD_CREATE, 16'hAAAA, 16'hFFFF, 1'b0);
        send_beat(CMD_CREATE, 16'h5555, 16'h0000, 1'b1);
        send_beat(CMD_TICK,   16'hFFFF, 16'h8010, 1'b1);

        // Random: three idling phases, one drained pause, one long result hold-off
        for (int k = 0; k < RANDOM_BEATS; k++) begin
            if (k == RANDOM_BEATS / 3) begin
                drain_results();
                send_idle_pct = 50;
                recv_idle_pct = 30;
            end else if (k == 2 * RANDOM_BEATS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (k == 2 * RANDOM_BEATS / 3 + 20) begin
                hold_req = 1'b1;
            end
            send_random();
        end

        // One fatal crash to end scheduling: damaged guard, or killing every task
        if ($urandom_range(1) == 0) begin
            send_beat(CMD_TICK, ADDR_W'($urandom_range(16'hFFFF)),
                      ADDR_W'($urandom_range(15)), 1'b0);
        end else begin
            while (!stopped)
                send_beat(CMD_TICK, ADDR_W'($urandom_range(16'hFFFF)),
                          ADDR_W'($urandom_range(15)), 1'b1);
        end
        // Halted block answers everything the same way
        repeat (6)
            send_beat(1'($urandom_range(1)), ADDR_W'($urandom_range(16'hFFFF)),
                      ADDR_W'($urandom_range(16'hFFFF)), 1'($urandom_range(1)));

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
